// ===== hw/rtl/atp_pkg.sv =====
// ----------------------------------------------------------------------------
// ADC to temperature package
// Shared widths, register indexes, reset values and the side payload type.
// ----------------------------------------------------------------------------
package atp_pkg;

  localparam int unsigned VOLT_W  = 19;
  localparam int unsigned CENTI_W = 9;
  localparam int unsigned TEMP_W  = 7;
  localparam int unsigned COEF_W  = 24;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_FOURTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_THIRD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_SECOND = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_FIRST  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_ZERO   = 3'd6;

  localparam logic [VOLT_W-1:0] CLAMP_LOW_RST  = 19'd10486;
  localparam logic [VOLT_W-1:0] CLAMP_HIGH_RST = 19'd85197;

  localparam logic signed [COEF_W-1:0] COEF_FOURTH_RST = 24'sd1554137;
  localparam logic signed [COEF_W-1:0] COEF_THIRD_RST  = -24'sd5642977;
  localparam logic signed [COEF_W-1:0] COEF_SECOND_RST = 24'sd7906918;
  localparam logic signed [COEF_W-1:0] COEF_FIRST_RST  = -24'sd5650842;
  localparam logic signed [COEF_W-1:0] COEF_ZERO_RST   = 24'sd2517074;

  typedef struct packed {
    logic [VOLT_W-1:0]  x;
    logic [CENTI_W-1:0] centi;
  } atp_side_t;

endpackage

// ===== hw/rtl/atp_horner_step.sv =====
// ----------------------------------------------------------------------------
// Horner step
// One multiply stage and one shift-and-add stage: acc * x / 2^16 + coef.
// ----------------------------------------------------------------------------
module atp_horner_step #(
  parameter int unsigned ACC_IN_W  = 24,
  parameter int unsigned ACC_OUT_W = 28
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  output logic                                  ready_o,
  input  logic signed [ACC_IN_W-1:0]            acc_i,
  input  atp_pkg::atp_side_t                    side_i,
  input  logic signed [atp_pkg::COEF_W-1:0]     coef_i,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output logic signed [ACC_OUT_W-1:0]           acc_o,
  output atp_pkg::atp_side_t                    side_o
);
  import atp_pkg::*;

  localparam int unsigned PROD_W = ACC_IN_W + VOLT_W + 1;
  localparam int unsigned SH_W   = PROD_W - FRAC_W;

  logic                     mul_valid_q, add_valid_q;
  logic                     mul_en, add_en;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  atp_side_t                mul_side_q, add_side_q;
  logic signed [SH_W-1:0]   shifted;
  logic signed [ACC_OUT_W-1:0] acc_d, acc_q;

  assign add_en  = !add_valid_q || ready_i;
  assign mul_en  = !mul_valid_q || add_en;
  assign ready_o = mul_en;

  assign prod_d  = PROD_W'(acc_i) * PROD_W'($signed({1'b0, side_i.x}));
  assign shifted = prod_q[PROD_W-1:FRAC_W];
  assign acc_d   = shifted[ACC_OUT_W-1:0] + ACC_OUT_W'(coef_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      add_valid_q <= 1'b0;
    end else begin
      if (mul_en) begin
        mul_valid_q <= valid_i;
      end
      if (add_en) begin
        add_valid_q <= mul_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q     <= prod_d;
      mul_side_q <= side_i;
    end
    if (add_en) begin
      acc_q      <= acc_d;
      add_side_q <= mul_side_q;
    end
  end

  assign valid_o = add_valid_q;
  assign acc_o   = acc_q;
  assign side_o  = add_side_q;

endmodule

// ===== hw/rtl/adc_to_temperature_polynomial.sv =====
// ----------------------------------------------------------------------------
// ADC to temperature polynomial
// Scales a raw ADC sample to volts, clamps it and evaluates a fourth-order
// polynomial to give the temperature in degrees Celsius.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle while the output is ready; eleven register
// stages with a valid bit each, and an empty stage is filled even while the
// output is stalled.
// Reset clears all stage valid bits and loads the default clamp limits and
// coefficients into the configuration registers.
module adc_to_temperature_polynomial #(
  parameter int unsigned ADC_BITS = 10
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [ADC_BITS-1:0]             adc_sample_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [atp_pkg::CENTI_W-1:0]     voltage_centivolts_o,
  output logic [atp_pkg::TEMP_W-1:0]      temperature_celsius_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [atp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [atp_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import atp_pkg::*;

  localparam int unsigned R_W  = ADC_BITS + 3;
  localparam logic [R_W-1:0] FULL  = R_W'((1 << ADC_BITS) - 1);
  localparam logic [R_W-1:0] FULL2 = R_W'(2 * ((1 << ADC_BITS) - 1));
  localparam logic [R_W-1:0] FULL3 = R_W'(3 * ((1 << ADC_BITS) - 1));
  localparam logic [R_W-1:0] FULL4 = R_W'(4 * ((1 << ADC_BITS) - 1));
  localparam logic [R_W-1:0] FULL5 = R_W'(5 * ((1 << ADC_BITS) - 1));
  localparam int unsigned A0_W = COEF_W;
  localparam int unsigned A1_W = 28;
  localparam int unsigned A2_W = 31;
  localparam int unsigned A3_W = 34;
  localparam int unsigned A4_W = 37;
  localparam int unsigned CENTI_P_W = VOLT_W + 7;

  logic [VOLT_W-1:0]        clamp_low_q, clamp_high_q;
  logic signed [COEF_W-1:0] coef4_q, coef3_q, coef2_q, coef1_q, coef0_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clamp_low_q  <= CLAMP_LOW_RST;
      clamp_high_q <= CLAMP_HIGH_RST;
      coef4_q      <= COEF_FOURTH_RST;
      coef3_q      <= COEF_THIRD_RST;
      coef2_q      <= COEF_SECOND_RST;
      coef1_q      <= COEF_FIRST_RST;
      coef0_q      <= COEF_ZERO_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_CLAMP_LOW:   clamp_low_q  <= cfg_data_i[VOLT_W-1:0];
        CFG_CLAMP_HIGH:  clamp_high_q <= cfg_data_i[VOLT_W-1:0];
        CFG_COEF_FOURTH: coef4_q      <= cfg_data_i;
        CFG_COEF_THIRD:  coef3_q      <= cfg_data_i;
        CFG_COEF_SECOND: coef2_q      <= cfg_data_i;
        CFG_COEF_FIRST:  coef1_q      <= cfg_data_i;
        CFG_COEF_ZERO:   coef0_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage 1 splits 5 * sample into whole volts and a remainder below full scale.
  logic           s1_valid_q, s1_en;
  logic [R_W-1:0] r5;
  logic [2:0]     qa_d, qa_q;
  logic [R_W-1:0] sub_d;
  logic [R_W-1:0] ra_full;
  logic [ADC_BITS-1:0] ra_q;

  assign r5 = R_W'(adc_sample_i) * R_W'(5);

  always_comb begin
    qa_d  = 3'd0;
    sub_d = '0;
    if (r5 >= FULL5) begin
      qa_d  = 3'd5;
      sub_d = FULL5;
    end else if (r5 >= FULL4) begin
      qa_d  = 3'd4;
      sub_d = FULL4;
    end else if (r5 >= FULL3) begin
      qa_d  = 3'd3;
      sub_d = FULL3;
    end else if (r5 >= FULL2) begin
      qa_d  = 3'd2;
      sub_d = FULL2;
    end else if (r5 >= FULL) begin
      qa_d  = 3'd1;
      sub_d = FULL;
    end
  end

  assign ra_full = r5 - sub_d;

  // Stage 2 builds the Q3.16 voltage, the centivolt value and the clamped x.
  // A remainder over 2^N - 1 is the remainder repeated as a binary fraction.
  logic                  s2_valid_q, s2_en;
  logic [2*ADC_BITS-1:0] rep;
  logic [VOLT_W-1:0]     volt;
  logic [CENTI_P_W-1:0]  centi_p;
  logic [VOLT_W-1:0]     x_lo, x_d;
  atp_side_t             s2_side_q;

  assign rep     = {ra_q, ra_q};
  assign volt    = {qa_q, rep[2*ADC_BITS-1 -: FRAC_W]};
  assign centi_p = CENTI_P_W'(volt) * CENTI_P_W'(100);
  assign x_lo    = (volt < clamp_low_q) ? clamp_low_q : volt;
  assign x_d     = (x_lo > clamp_high_q) ? clamp_high_q : x_lo;

  logic                    h1_ready, h2_ready, h3_ready, h4_ready;
  logic                    h1_valid, h2_valid, h3_valid, h4_valid;
  logic signed [A1_W-1:0]  acc1;
  logic signed [A2_W-1:0]  acc2;
  logic signed [A3_W-1:0]  acc3;
  logic signed [A4_W-1:0]  acc4;
  atp_side_t               side1, side2, side3, side4;

  logic                    out_valid_q, out_en;
  logic [TEMP_W-1:0]       temp_d, temp_q;
  logic [CENTI_W-1:0]      centi_q;

  assign out_en     = !out_valid_q || out_ready_i;
  assign s2_en      = !s2_valid_q || h1_ready;
  assign s1_en      = !s1_valid_q || s2_en;
  assign in_ready_o = s1_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_en) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_en) begin
        out_valid_q <= h4_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      qa_q <= qa_d;
      ra_q <= ra_full[ADC_BITS-1:0];
    end
    if (s2_en) begin
      s2_side_q.x     <= x_d;
      s2_side_q.centi <= centi_p[FRAC_W +: CENTI_W];
    end
    if (out_en) begin
      temp_q  <= temp_d;
      centi_q <= side4.centi;
    end
  end

  atp_horner_step #(.ACC_IN_W(A0_W), .ACC_OUT_W(A1_W)) u_step1 (
    .clk_i, .rst_ni,
    .valid_i(s2_valid_q), .ready_o(h1_ready),
    .acc_i(coef4_q), .side_i(s2_side_q), .coef_i(coef3_q),
    .valid_o(h1_valid), .ready_i(h2_ready), .acc_o(acc1), .side_o(side1)
  );

  atp_horner_step #(.ACC_IN_W(A1_W), .ACC_OUT_W(A2_W)) u_step2 (
    .clk_i, .rst_ni,
    .valid_i(h1_valid), .ready_o(h2_ready),
    .acc_i(acc1), .side_i(side1), .coef_i(coef2_q),
    .valid_o(h2_valid), .ready_i(h3_ready), .acc_o(acc2), .side_o(side2)
  );

  atp_horner_step #(.ACC_IN_W(A2_W), .ACC_OUT_W(A3_W)) u_step3 (
    .clk_i, .rst_ni,
    .valid_i(h2_valid), .ready_o(h3_ready),
    .acc_i(acc2), .side_i(side2), .coef_i(coef1_q),
    .valid_o(h3_valid), .ready_i(h4_ready), .acc_o(acc3), .side_o(side3)
  );

  atp_horner_step #(.ACC_IN_W(A3_W), .ACC_OUT_W(A4_W)) u_step4 (
    .clk_i, .rst_ni,
    .valid_i(h3_valid), .ready_o(h4_ready),
    .acc_i(acc3), .side_i(side3), .coef_i(coef0_q),
    .valid_o(h4_valid), .ready_i(out_en), .acc_o(acc4), .side_o(side4)
  );

  // Negative values go to zero; large values saturate at the top of the range.
  always_comb begin
    if (acc4[A4_W-1]) begin
      temp_d = '0;
    end else if (|acc4[A4_W-2:14+TEMP_W]) begin
      temp_d = '1;
    end else begin
      temp_d = acc4[14 +: TEMP_W];
    end
  end

  assign out_valid_o           = out_valid_q;
  assign voltage_centivolts_o  = centi_q;
  assign temperature_celsius_o = temp_q;

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// ADC to temperature polynomial testbench
// Streams ADC samples through the block under random gaps and output stalls,
// rewrites the clamp and coefficient registers between phases, and checks
// every result against a fixed-point Horner predictor kept in the bench.
// ----------------------------------------------------------------------------
module testbench;
  import atp_pkg::*;

  localparam int unsigned ADC_BITS = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef struct packed {
    logic [CENTI_W-1:0] centivolts;
    logic [TEMP_W-1:0]  celsius;
  } reading_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready_o;
  logic [ADC_BITS-1:0]   adc_sample = '0;
  logic                  out_valid_o;
  logic                  out_ready = 1'b0;
  logic [CENTI_W-1:0]    voltage_centivolts_o;
  logic [TEMP_W-1:0]     temperature_celsius_o;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic                     stall_en = 1'b1;
  bit                       gaps_en = 1'b1;
  int                       ready_hold = 0;
  int                       mismatches = 0;
  int                       results_seen = 0;
  int                       samples_sent = 0;
  int                       config_writes = 0;
  reading_t                 pending_readings [$];
  logic [VOLT_W-1:0]        clamp_low_q16 = CLAMP_LOW_RST;
  logic [VOLT_W-1:0]        clamp_high_q16 = CLAMP_HIGH_RST;
  logic signed [COEF_W-1:0] coef_q14 [5];

  adc_to_temperature_polynomial #(
    .ADC_BITS(ADC_BITS)
  ) dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid),
    .in_ready_o           (in_ready_o),
    .adc_sample_i         (adc_sample),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready),
    .voltage_centivolts_o (voltage_centivolts_o),
    .temperature_celsius_o(temperature_celsius_o),
    .cfg_valid_i          (cfg_valid),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_index_i          (cfg_index),
    .cfg_data_i           (cfg_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic int random_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [COEF_W-1:0] coef_reset(logic [CFG_IDX_W-1:0] idx);
    case (idx)
      CFG_COEF_FOURTH: return COEF_FOURTH_RST;
      CFG_COEF_THIRD:  return COEF_THIRD_RST;
      CFG_COEF_SECOND: return COEF_SECOND_RST;
      CFG_COEF_FIRST:  return COEF_FIRST_RST;
      default:         return COEF_ZERO_RST;
    endcase
  endfunction

  function automatic reading_t predict_reading(logic [ADC_BITS-1:0] sample);
    longint unsigned full_scale;
    longint unsigned volts_q16;
    longint unsigned x;
    longint          acc;
    longint          degrees;
    reading_t        r;
    full_scale = (64'd1 << ADC_BITS) - 1;
    volts_q16 = (64'(sample) * 5 * 65536) / full_scale;
    r.centivolts = CENTI_W'((volts_q16 * 100) >> 16);
    x = volts_q16;
    if (x < clamp_low_q16) x = clamp_low_q16;
    if (x > clamp_high_q16) x = clamp_high_q16;
    acc = coef_q14[0];
    for (int k = 1; k < 5; k++) begin
      acc = ((acc * longint'(x)) >>> 16) + longint'(coef_q14[k]);
    end
    degrees = acc / 16384;
    if (degrees < 0) degrees = 0;
    if (degrees > 127) degrees = 127;
    r.celsius = TEMP_W'(degrees);
    return r;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] settings_value(logic [CFG_IDX_W-1:0] idx,
                                                           int mode);
    bit is_clamp;
    bit extreme;
    is_clamp = (idx == CFG_CLAMP_LOW) || (idx == CFG_CLAMP_HIGH);
    extreme = ($urandom_range(0, 2) == 0);
    case (mode)
      0: begin
        if (idx == CFG_CLAMP_LOW) begin
          return 24'(int'(CLAMP_LOW_RST) + int'($urandom_range(0, 4000)) - 2000);
        end else if (idx == CFG_CLAMP_HIGH) begin
          return 24'(int'(CLAMP_HIGH_RST) + int'($urandom_range(0, 40000)) - 20000);
        end
        return 24'(int'(coef_reset(idx)) + int'($urandom_range(0, 4000)) - 2000);
      end
      1: return 24'($urandom());
      default: begin
        if (is_clamp && extreme) return $urandom_range(0, 1) ? 24'd327680 : 24'd0;
        if (is_clamp) return 24'($urandom_range(0, 327680));
        if (extreme) return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
        return 24'($urandom());
      end
    endcase
  endfunction

  function automatic logic [ADC_BITS-1:0] pick_sample(int mode);
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return ADC_BITS'($urandom_range(0, 1023));
    if (r < 8 && mode == 0) return ADC_BITS'($urandom_range(30, 280));
    if (r < 8) return ADC_BITS'($urandom());
    return $urandom_range(0, 1) ? ADC_BITS'(1023) : ADC_BITS'(0);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    if (!stall_en) begin
      out_ready <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (out_ready) begin
      out_ready <= 1'b0;
      ready_hold <= random_idle();
    end else begin
      out_ready <= 1'b1;
      ready_hold <= $urandom_range(0, 12);
    end
  end

  always @(posedge clk_i) begin : check_results
    reading_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      results_seen++;
      if (pending_readings.size() == 0) begin
        report_mismatch("result with no outstanding request, temperature",
                        int'(temperature_celsius_o), -1);
      end else begin
        want = pending_readings.pop_front();
        if (voltage_centivolts_o !== want.centivolts) begin
          report_mismatch("voltage_centivolts", int'(voltage_centivolts_o),
                          int'(want.centivolts));
        end
        if (temperature_celsius_o !== want.celsius) begin
          report_mismatch("temperature_celsius", int'(temperature_celsius_o),
                          int'(want.celsius));
        end
      end
    end
  end

  task automatic send_sample(input logic [ADC_BITS-1:0] sample);
    int gap;
    gap = gaps_en ? random_idle() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    adc_sample <= sample;
    do @(posedge clk_i); while (!in_ready_o);
    pending_readings.push_back(predict_reading(sample));
    samples_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    config_writes++;
    case (idx)
      CFG_CLAMP_LOW:  clamp_low_q16 = data[VOLT_W-1:0];
      CFG_CLAMP_HIGH: clamp_high_q16 = data[VOLT_W-1:0];
      CFG_COEF_FOURTH, CFG_COEF_THIRD, CFG_COEF_SECOND, CFG_COEF_FIRST,
      CFG_COEF_ZERO:  coef_q14[idx - CFG_COEF_FOURTH] = data;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_values();
    send_sample(10'd0);
    send_sample(10'd1023);
    send_sample(10'd1);
    send_sample(10'd1022);
    send_sample(10'd33);
    send_sample(10'd266);
    send_sample(10'h155);
    send_sample(10'h2AA);
    send_sample(10'd512);
  endtask

  task automatic test_extreme_settings();
    // Full-range clamps with every coefficient at its positive limit.
    write_reg(CFG_CLAMP_LOW, 24'd0);
    write_reg(CFG_CLAMP_HIGH, 24'd327680);
    for (int k = 0; k < 5; k++) write_reg(CFG_COEF_FOURTH + 3'(k), 24'h7FFFFF);
    end_writes();
    send_sample(10'd0);
    send_sample(10'd1023);
    send_sample(10'd700);

    // Crossed clamps, so the upper limit decides, with negative coefficients.
    write_reg(CFG_CLAMP_LOW, 24'd200000);
    write_reg(CFG_CLAMP_HIGH, 24'd50000);
    for (int k = 0; k < 5; k++) write_reg(CFG_COEF_FOURTH + 3'(k), 24'h800000);
    end_writes();
    send_sample(10'd0);
    send_sample(10'd1023);

    // Clamps above full scale and a negative constant polynomial.
    write_reg(CFG_CLAMP_LOW, 24'hFF0000);
    write_reg(CFG_CLAMP_HIGH, 24'hFFFFFF);
    for (int k = 0; k < 4; k++) write_reg(CFG_COEF_FOURTH + 3'(k), 24'd0);
    write_reg(CFG_COEF_ZERO, 24'h800000);
    end_writes();
    send_sample(10'd5);
    send_sample(10'd1000);

    // A large constant saturates high; a write to the spare index changes nothing.
    write_reg(CFG_COEF_ZERO, 24'h7FFFFF);
    write_reg(CFG_UNUSED, 24'h123456);
    end_writes();
    send_sample(10'd512);
    send_sample(10'd1023);
  endtask

  task automatic test_random_stream();
    int mode;
    bit quiet;
    for (int phase = 0; phase < 10; phase++) begin
      mode = phase % 3;
      quiet = (phase % 4 == 3);
      gaps_en = !quiet;
      stall_en <= !quiet;
      if (phase % 2 == 0) write_reg(CFG_UNUSED, 24'($urandom()));
      for (int idx = 0; idx < 7; idx++) begin
        write_reg(CFG_IDX_W'(idx), settings_value(CFG_IDX_W'(idx), mode));
      end
      end_writes();
      repeat (150) send_sample(pick_sample(mode));
    end
    gaps_en = 1'b1;
    stall_en <= 1'b1;
  endtask

  initial begin
    coef_q14[0] = COEF_FOURTH_RST;
    coef_q14[1] = COEF_THIRD_RST;
    coef_q14[2] = COEF_SECOND_RST;
    coef_q14[3] = COEF_FIRST_RST;
    coef_q14[4] = COEF_ZERO_RST;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_extreme_settings();
    test_random_stream();

    drain();
    repeat (30) @(posedge clk_i);
    $display("Checked %0d results from %0d samples over %0d register writes.",
             results_seen, samples_sent, config_writes);
    $display("Covered reset settings, coefficient limits, crossed and oversized clamps,");
    $display("both saturation ends and random settings under gaps and stalls.");
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/atp_pkg.sv
hw/rtl/atp_horner_step.sv
hw/rtl/adc_to_temperature_polynomial.sv
verif/testbench.sv
